>>> hdl/first_fit_arena_heap_allocator_defines.svh
// Assertion macros used by the allocator RTL.
// No dependencies; included by ffa_engine, which carries concurrent checks.
`ifndef FIRST_FIT_ARENA_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_ARENA_HEAP_ALLOCATOR_DEFINES_SVH

// Checked only outside reset.
`define FFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define FFA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> hdl/ffa_pkg.sv
// Shared types and constants for the first-fit arena heap allocator.
// No dependencies.
package ffa_pkg;

    localparam int ADDR_BITS  = 16;
    localparam int REQ_BITS   = 15;
    localparam int HEAP_BYTES = 16384;
    localparam int SLOT_BITS  = $clog2(HEAP_BYTES);
    localparam int MAX_ARENAS = 8;
    localparam int LVL_BITS   = $clog2(MAX_ARENAS);
    localparam int ENTRY_BITS = REQ_BITS + ADDR_BITS;   // {next, size}

    localparam logic [ADDR_BITS-1:0] HDR_BYTES = ADDR_BITS'(4);
    localparam logic [ADDR_BITS-1:0] ARENA_REC = ADDR_BITS'(8);

    typedef enum logic [2:0] {
        K_ALLOC = 3'd0,
        K_FREE  = 3'd1,
        K_ENTER = 3'd2,
        K_LEAVE = 3'd3,
        K_RESET = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OOM       = 2'd1,
        ST_NEST_FULL = 2'd2,
        ST_LEAVE_IGN = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_BUMP,
        S_FREE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [ADDR_BITS-1:0] base;
        logic [ADDR_BITS-1:0] limit;
    } t_cfg;

    typedef struct packed {
        logic [2:0]           kind;
        logic [REQ_BITS-1:0]  req;
        logic [ADDR_BITS-1:0] addr;
    } t_item;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        t_status              status;
        logic [ADDR_BITS-1:0] heap_end;
    } t_result;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [SLOT_BITS-1:0]  slot;
        logic [ENTRY_BITS-1:0] wdata;
    } t_mem_req;

endpackage

>>> hdl/ffa_chunk_ram.sv
// Chunk header store: one {next, size} entry per heap address slot.
// Depends on ffa_pkg. Single port, registered read.
module ffa_chunk_ram
    import ffa_pkg::*;
(
    input  logic                  i_clk,
    input  t_mem_req              i_req,
    output logic [ENTRY_BITS-1:0] o_rdata
);

    logic [ENTRY_BITS-1:0] r_mem [HEAP_BYTES];
    logic [ENTRY_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.slot] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.slot];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/ffa_engine.sv
// Allocator sequencer: arena state, free-list walk, bump and free paths.
// Depends on ffa_pkg and the macro header; drives the chunk store through the memory request struct.
`include "first_fit_arena_heap_allocator_defines.svh"
module ffa_engine
    import ffa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_item                 i_item,
    input  logic                  i_out_free,
    output logic                  o_done,
    output t_result               o_res,
    output t_mem_req              o_mem,
    input  logic [ENTRY_BITS-1:0] i_mem_rdata
);

    t_state                r_state, n_state;
    logic [2:0]            r_kind;
    logic [REQ_BITS-1:0]   r_req, n_req;
    logic [ADDR_BITS-1:0]  r_addr, n_addr;
    logic [ADDR_BITS-1:0]  r_cur, n_cur;
    logic [ADDR_BITS-1:0]  r_prev, n_prev;
    logic [REQ_BITS-1:0]   r_prev_size, n_prev_size;
    logic                  r_have_prev, n_have_prev;
    logic [SLOT_BITS-1:0]  r_cnt, n_cnt;
    logic [ADDR_BITS-1:0]  r_top, n_top;
    logic [LVL_BITS-1:0]   r_lvl, n_lvl;
    logic [ADDR_BITS-1:0]  r_heads [MAX_ARENAS];
    logic [ADDR_BITS-1:0]  n_heads [MAX_ARENAS];
    logic [ADDR_BITS-1:0]  r_bases [MAX_ARENAS];
    logic [ADDR_BITS-1:0]  n_bases [MAX_ARENAS];
    t_result               r_res, n_res;

    logic [REQ_BITS-1:0]   rd_size;
    logic [ADDR_BITS-1:0]  rd_next;
    logic [ADDR_BITS:0]    bump_end;
    logic [ADDR_BITS-1:0]  free_chunk;
    logic [ADDR_BITS-1:0]  free_end;
    logic [LVL_BITS-1:0]   lvl_up;
    logic                  walk_last;

    assign rd_size    = i_mem_rdata[REQ_BITS-1:0];
    assign rd_next    = i_mem_rdata[ENTRY_BITS-1:REQ_BITS];
    assign bump_end   = {1'b0, r_top} + {{(ADDR_BITS+1-REQ_BITS){1'b0}}, r_req}
                      + {1'b0, HDR_BYTES};
    assign free_chunk = i_item.addr - HDR_BYTES;
    assign free_end   = r_addr + HDR_BYTES + {{(ADDR_BITS-REQ_BITS){1'b0}}, rd_size};
    assign lvl_up     = r_lvl + LVL_BITS'(1);
    assign walk_last  = (rd_next == '0) || (r_cnt == SLOT_BITS'(HEAP_BYTES - 1));

    assign o_ready = (r_state == S_IDLE);
    assign o_res   = r_res;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_item.kind == K_ALLOC) begin
                        n_state = (r_heads[r_lvl] != '0) ? S_WALK : S_BUMP;
                    end else if (i_item.kind == K_FREE) begin
                        n_state = S_FREE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_WALK: begin
                if (rd_size >= r_req) begin
                    n_state = S_DONE;
                end else if (walk_last) begin
                    n_state = S_BUMP;
                end
            end
            S_BUMP: n_state = S_DONE;
            S_FREE: n_state = S_DONE;
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb begin
        n_req       = r_req;
        n_addr      = r_addr;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_prev_size = r_prev_size;
        n_have_prev = r_have_prev;
        n_cnt       = r_cnt;
        n_top       = r_top;
        n_lvl       = r_lvl;
        n_heads     = r_heads;
        n_bases     = r_bases;
        n_res       = r_res;
        o_mem       = '0;
        o_done      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req = i_item.req;
                    n_res = '{addr: '0, status: ST_OK, heap_end: r_top};
                    unique case (i_item.kind)
                        K_ALLOC: begin
                            n_cur       = r_heads[r_lvl];
                            n_have_prev = 1'b0;
                            n_cnt       = '0;
                            o_mem.re    = (r_heads[r_lvl] != '0);
                            o_mem.slot  = r_heads[r_lvl][SLOT_BITS-1:0];
                        end
                        K_FREE: begin
                            n_addr     = free_chunk;
                            o_mem.re   = 1'b1;
                            o_mem.slot = free_chunk[SLOT_BITS-1:0];
                        end
                        K_ENTER: begin
                            if (r_lvl == LVL_BITS'(MAX_ARENAS - 1)) begin
                                n_res.status = ST_NEST_FULL;
                            end else begin
                                n_lvl            = lvl_up;
                                n_bases[lvl_up]  = r_top;
                                n_heads[lvl_up]  = '0;
                                n_top            = r_top + ARENA_REC;
                                n_res.heap_end   = r_top + ARENA_REC;
                            end
                        end
                        K_LEAVE: begin
                            if (r_lvl == '0) begin
                                n_res.status = ST_LEAVE_IGN;
                            end else begin
                                n_top          = r_bases[r_lvl];
                                n_lvl          = r_lvl - LVL_BITS'(1);
                                n_res.heap_end = r_bases[r_lvl];
                            end
                        end
                        K_RESET: begin
                            for (int i = 0; i < MAX_ARENAS; i++) begin
                                n_heads[i] = '0;
                                n_bases[i] = '0;
                            end
                            n_bases[0]     = i_cfg.base;
                            n_lvl          = '0;
                            n_top          = i_cfg.base + ARENA_REC;
                            n_res.heap_end = i_cfg.base + ARENA_REC;
                        end
                        default: ;  // unused kinds: no change, zero address
                    endcase
                end
            end
            S_WALK: begin
                if (rd_size >= r_req) begin
                    // first fit: unlink without splitting
                    if (!r_have_prev) begin
                        n_heads[r_lvl] = rd_next;
                    end else begin
                        o_mem.we    = 1'b1;
                        o_mem.slot  = r_prev[SLOT_BITS-1:0];
                        o_mem.wdata = {rd_next, r_prev_size};
                    end
                    n_res = '{addr: r_cur + HDR_BYTES, status: ST_OK, heap_end: r_top};
                end else begin
                    n_prev      = r_cur;
                    n_prev_size = rd_size;
                    n_have_prev = 1'b1;
                    n_cnt       = r_cnt + SLOT_BITS'(1);
                    n_cur       = rd_next;
                    o_mem.re    = !walk_last;
                    o_mem.slot  = rd_next[SLOT_BITS-1:0];
                end
            end
            S_BUMP: begin
                if (bump_end > {1'b0, i_cfg.limit}) begin
                    n_res = '{addr: '0, status: ST_OOM, heap_end: r_top};
                end else begin
                    o_mem.we    = 1'b1;
                    o_mem.slot  = r_top[SLOT_BITS-1:0];
                    o_mem.wdata = {{ADDR_BITS{1'b0}}, r_req};
                    n_top       = bump_end[ADDR_BITS-1:0];
                    n_res       = '{addr: r_top + HDR_BYTES, status: ST_OK,
                                    heap_end: bump_end[ADDR_BITS-1:0]};
                end
            end
            S_FREE: begin
                if (free_end == r_top) begin
                    n_top          = r_addr;
                    n_res.heap_end = r_addr;
                end else if (r_addr != '0) begin
                    // push onto the head of this level's list
                    o_mem.we       = 1'b1;
                    o_mem.slot     = r_addr[SLOT_BITS-1:0];
                    o_mem.wdata    = {r_heads[r_lvl], rd_size};
                    n_heads[r_lvl] = r_addr;
                end
            end
            S_DONE: o_done = i_out_free;
            default: ;
        endcase
    end

    // heap_base resets to zero, so the outermost record sits at 0 and the end at 8
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= ARENA_REC;
            r_lvl   <= '0;
            for (int i = 0; i < MAX_ARENAS; i++) begin
                r_heads[i] <= '0;
                r_bases[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_lvl   <= n_lvl;
            r_heads <= n_heads;
            r_bases <= n_bases;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_kind <= i_item.kind;
        end
        r_req       <= n_req;
        r_addr      <= n_addr;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_prev_size <= n_prev_size;
        r_have_prev <= n_have_prev;
        r_cnt       <= n_cnt;
        r_res       <= n_res;
    end

    // A single port: a read and a write never share a cycle.
    `FFA_ASSERT_ALWAYS(a_one_access, !(o_mem.we && o_mem.re), "chunk store read and write collide")
    // A walk only runs for an allocate.
    `FFA_ASSERT(a_walk_kind, (r_state == S_WALK) |-> (r_kind == K_ALLOC), "walk outside allocate")
    // An out of memory result never carries a pointer.
    `FFA_ASSERT(a_oom_zero, (o_done && r_res.status == ST_OOM) |-> (r_res.addr == '0), "pointer on oom")
    // Handing off a result frees the engine at the next edge.
    `FFA_ASSERT(a_done_idle, o_done |=> (r_state == S_IDLE), "engine stuck after handoff")

endmodule

>>> hdl/first_fit_arena_heap_allocator.sv
// First-fit arena heap allocator. Each transaction (allocate, free, enter or leave
// arena, reset heap) yields one result transaction. Chunk headers {next, size} live
// in a 16384-entry single-port store with a registered read; the free list is
// walked one header per cycle through that port. Allocate visits free-list chunks
// in order and falls back to the heap end when none fits; free reads the chunk
// header first; enter, leave and reset heap touch no header. A result sits in an
// output register, so the next transaction is accepted while it waits to be taken.
// Depends on ffa_pkg, ffa_engine and ffa_chunk_ram.
module first_fit_arena_heap_allocator
    import ffa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: index 0 heap_base, 1 heap_limit
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [14:0] req_bytes, [30:15] address, [31] zero
    input  logic [2:0]  s_axis_tuser,   // [2:0] kind
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] address_res, [31:16] heap_end
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    t_cfg                  r_cfg;
    logic                  r_out_valid;
    t_result               r_out;
    t_item                 item;
    t_result               eng_res;
    t_mem_req              mem_req;
    logic [ENTRY_BITS-1:0] mem_rdata;
    logic                  eng_done;
    logic                  out_free;

    // configuration registers: reset heap_base 0, heap_limit 16384
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{base: 16'h0000, limit: 16'h4000};
        end else if (i_cfg_we) begin
            if (i_cfg_idx) begin
                r_cfg.limit <= i_cfg_wdata;
            end else begin
                r_cfg.base <= i_cfg_wdata;
            end
        end
    end

    assign item.kind = s_axis_tuser;
    assign item.req  = s_axis_tdata[14:0];
    assign item.addr = s_axis_tdata[30:15];

    // output slot is free when empty or being drained this cycle
    assign out_free = !r_out_valid || m_axis_tready;

    ffa_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_item      (item),
        .i_out_free  (out_free),
        .o_done      (eng_done),
        .o_res       (eng_res),
        .o_mem       (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    ffa_chunk_ram u_chunk_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_done) begin
            r_out <= eng_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.heap_end, r_out.addr};
    assign m_axis_tuser  = r_out.status;

endmodule

>>> tb/tb_first_fit_arena_heap_allocator.sv
// Self-checking testbench for first_fit_arena_heap_allocator: directed and random
// heap transactions, checked against a behavioral model of the allocator.
// Depends on ffa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_first_fit_arena_heap_allocator
    import ffa_pkg::*;
;

    localparam int N_RANDOM = 430;
    localparam int CFG_BASE = 0;
    localparam int CFG_LIMIT = 1;

    typedef struct {
        t_kind            kind;
        logic [14:0]      req;
        logic [15:0]      addr;
    } t_heap_op;

    typedef struct {
        logic [15:0] addr;
        t_status     status;
        logic [15:0] heap_end;
    } t_heap_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // [14:0] req_bytes, [30:15] address, [31] zero
    logic [2:0]  s_axis_tuser;    // [2:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // [15:0] address_res, [31:16] heap_end
    logic [1:0]  m_axis_tuser;    // [1:0] status

    first_fit_arena_heap_allocator i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // ---------------- allocator model state ----------------
    logic [14:0] hdr_size [HEAP_BYTES];
    logic [15:0] hdr_next [HEAP_BYTES];
    logic [15:0] mdl_top;
    logic [15:0] mdl_heads [MAX_ARENAS];
    logic [15:0] mdl_bases [MAX_ARENAS];
    int          mdl_level;
    logic [15:0] mdl_base;
    logic [15:0] mdl_limit;
    // stimulus-side shadow: user pointers currently live (allocated, not freed)
    logic [15:0] live_ptrs [$];

    t_heap_op  pending_ops [$];
    t_heap_res expected_results [$];
    int        errors;
    int        hold_off;      // cycles the receiver must hold tready low
    bit        stall_req;

    function automatic int slot_of(logic [15:0] a);
        return int'(a) % HEAP_BYTES;
    endfunction

    function automatic void heap_restart();
        mdl_top = mdl_base + 16'd8;
        mdl_level = 0;
        foreach (mdl_heads[i]) begin
            mdl_heads[i] = '0;
            mdl_bases[i] = '0;
        end
        mdl_bases[0] = mdl_base;
        live_ptrs.delete();
    endfunction

    // Computes the result of one transaction and advances the model.
    function automatic t_heap_res heap_apply(t_heap_op op);
        t_heap_res r;
        logic [15:0] cur, prev, nxt, chunk, cend;
        logic [16:0] new_end;
        bit have_prev, found;
        int n;
        r.addr = '0;
        r.status = ST_OK;
        case (op.kind)
            K_ALLOC: begin
                cur = mdl_heads[mdl_level];
                have_prev = 0;
                found = 0;
                prev = '0;
                for (n = 0; n < HEAP_BYTES && cur != 0; n++) begin
                    nxt = hdr_next[slot_of(cur)];
                    if (hdr_size[slot_of(cur)] >= op.req) begin
                        if (!have_prev) mdl_heads[mdl_level] = nxt;
                        else hdr_next[slot_of(prev)] = nxt;
                        r.addr = cur + HDR_BYTES;
                        found = 1;
                        break;
                    end
                    prev = cur;
                    have_prev = 1;
                    cur = nxt;
                end
                if (!found) begin
                    new_end = {1'b0, mdl_top} + op.req + 17'd4;
                    if (new_end > {1'b0, mdl_limit}) begin
                        r.status = ST_OOM;
                    end else begin
                        hdr_size[slot_of(mdl_top)] = op.req;
                        hdr_next[slot_of(mdl_top)] = '0;
                        r.addr = mdl_top + HDR_BYTES;
                        mdl_top = new_end[15:0];
                    end
                end
            end
            K_FREE: begin
                chunk = op.addr - HDR_BYTES;
                cend = chunk + HDR_BYTES + 16'(hdr_size[slot_of(chunk)]);
                if (cend == mdl_top) begin
                    mdl_top = chunk;
                end else if (chunk != 0) begin
                    hdr_next[slot_of(chunk)] = mdl_heads[mdl_level];
                    mdl_heads[mdl_level] = chunk;
                end
            end
            K_ENTER: begin
                if (mdl_level + 1 >= MAX_ARENAS) begin
                    r.status = ST_NEST_FULL;
                end else begin
                    mdl_level++;
                    mdl_bases[mdl_level] = mdl_top;
                    mdl_heads[mdl_level] = '0;
                    mdl_top = mdl_top + ARENA_REC;
                    live_ptrs.delete();
                end
            end
            K_LEAVE: begin
                if (mdl_level == 0) begin
                    r.status = ST_LEAVE_IGN;
                end else begin
                    mdl_top = mdl_bases[mdl_level];
                    mdl_level--;
                    live_ptrs.delete();
                end
            end
            K_RESET: heap_restart();
            default: ;
        endcase
        r.heap_end = mdl_top;
        if (op.kind == K_ALLOC && r.status == ST_OK) live_ptrs.push_back(r.addr);
        return r;
    endfunction

    // Queues one transaction; predicted at generation time since order is fixed.
    task automatic queue_op(t_kind k, int req, logic [15:0] a);
        t_heap_op op;
        op.kind = k;
        op.req = 15'(req);
        op.addr = a;
        pending_ops.push_back(op);
        expected_results.push_back(heap_apply(op));
    endtask

    // Free only pointers whose header has been written, so no unwritten entry is read.
    task automatic queue_free_live();
        int idx;
        logic [15:0] p;
        if (live_ptrs.size() == 0) begin
            queue_op(K_ALLOC, $urandom_range(0, 64), 16'($urandom));
            return;
        end
        idx = $urandom_range(0, live_ptrs.size() - 1);
        p = live_ptrs[idx];
        live_ptrs.delete(idx);
        queue_op(K_FREE, $urandom_range(0, 32767), p);
    endtask

    task automatic cfg_write(int idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx[0];
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_BASE) mdl_base = val;
        else mdl_limit = val;
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // ---------------- clock ----------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------- driver ----------------
    int src_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap <= 0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // hold the offered transaction
        end else begin
            if (s_axis_tvalid && s_axis_tready) void'(pending_ops.pop_front());
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_ops.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0)
                         && pending_ops.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {1'b0, pending_ops[0].addr, pending_ops[0].req};
                s_axis_tuser <= pending_ops[0].kind;
                src_gap <= gap_len();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- receiver / monitor ----------------
    int sink_gap;
    always @(posedge i_clk) begin
        t_heap_res e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap <= 0;
            hold_off <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result tdata=%h tuser=%0d",
                             $time, m_axis_tdata, m_axis_tuser);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_axis_tdata[15:0] !== e.addr) begin
                        $display("%0t: address_res expected %h actual %h",
                                 $time, e.addr, m_axis_tdata[15:0]);
                        errors++;
                    end
                    if (m_axis_tuser !== e.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata[31:16] !== e.heap_end) begin
                        $display("%0t: heap_end expected %h actual %h",
                                 $time, e.heap_end, m_axis_tdata[31:16]);
                        errors++;
                    end
                end
            end
            // long hold-off so the input side backs up
            if (stall_req && hold_off == 0) begin
                hold_off <= 300;
                m_axis_tready <= 1'b0;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_axis_tready <= (hold_off == 1);
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) sink_gap <= gap_len();
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic random_phase(int count);
        int k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            if (k < 40) queue_op(K_ALLOC, ($urandom_range(0, 15) == 0)
                                 ? $urandom_range(0, 32767) : $urandom_range(0, 48),
                                 16'($urandom));
            else if (k < 72) queue_free_live();
            else if (k < 82) queue_op(K_ENTER, $urandom_range(0, 32767), 16'($urandom));
            else if (k < 92) queue_op(K_LEAVE, $urandom_range(0, 32767), 16'($urandom));
            else if (k < 95) queue_op(K_RESET, $urandom_range(0, 32767), 16'($urandom));
            else queue_op(t_kind'($urandom_range(5, 7)), $urandom_range(0, 32767),
                          16'($urandom));
        end
    endtask

    initial begin
        errors = 0;
        stall_req = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        foreach (hdr_size[i]) begin
            hdr_size[i] = '0;
            hdr_next[i] = '0;
        end
        mdl_base = 16'd0;
        mdl_limit = 16'd16384;
        heap_restart();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every kind, nesting full, leave at outermost
        queue_op(K_LEAVE, 0, 16'h0000);
        queue_op(K_ALLOC, 0, 16'hffff);
        queue_op(K_ALLOC, 16384, 16'h0000);          // out of memory
        queue_op(K_ALLOC, 32767, 16'hffff);          // out of memory
        queue_op(K_ALLOC, 20, 16'h0000);
        queue_op(K_ALLOC, 8, 16'h0000);
        queue_op(K_ALLOC, 4, 16'h0000);
        queue_op(K_FREE, 0, 16'd16);                 // interior chunk to free list
        queue_op(K_ALLOC, 16, 16'h0000);             // first-fit hit
        queue_op(K_FREE, 0, live_ptrs[live_ptrs.size()-1]); // same chunk back to the list
        for (int i = 0; i < MAX_ARENAS; i++) queue_op(K_ENTER, 0, 16'h0);  // last is full
        queue_op(K_ALLOC, 12, 16'h0);
        for (int i = 0; i < MAX_ARENAS; i++) queue_op(K_LEAVE, 0, 16'h0);
        queue_op(K_RESET, 15'h7fff, 16'hffff);
        queue_op(t_kind'(3'd7), 15'h7fff, 16'hffff);
        wait_drained();

        random_phase(N_RANDOM / 4);
        wait_drained();

        // backpressure: receiver stalls long while items keep coming
        stall_req <= 1'b1;
        @(posedge i_clk);
        stall_req <= 1'b0;
        random_phase(N_RANDOM / 4);
        wait_drained();

        // base near the top of the address space: arena records wrap
        queue_op(K_RESET, 0, 16'h0);
        wait_drained();
        cfg_write(CFG_BASE, 16'hffe0);
        cfg_write(CFG_LIMIT, 16'hffff);
        queue_op(K_RESET, 0, 16'h0);
        random_phase(N_RANDOM / 8);
        wait_drained();

        // tight limit: frequent out-of-memory
        cfg_write(CFG_BASE, 16'h1000);
        cfg_write(CFG_LIMIT, 16'h1100);
        queue_op(K_RESET, 0, 16'h0);
        random_phase(N_RANDOM / 8);
        wait_drained();

        // zero limit, then base 0 with the widest limit
        cfg_write(CFG_LIMIT, 16'h0000);
        queue_op(K_ALLOC, 0, 16'h0);
        wait_drained();
        cfg_write(CFG_BASE, 16'h0000);
        cfg_write(CFG_LIMIT, 16'hffff);
        queue_op(K_RESET, 0, 16'h0);
        random_phase(N_RANDOM / 4);
        wait_drained();

        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+hdl
hdl/ffa_pkg.sv
hdl/ffa_chunk_ram.sv
hdl/ffa_engine.sv
hdl/first_fit_arena_heap_allocator.sv
tb/tb_first_fit_arena_heap_allocator.sv
